>>> hdl/orthonormal_basis_from_axis_macros.svh
// Assertion macros shared by the orthonormal basis block.
`ifndef ORTHONORMAL_BASIS_FROM_AXIS_MACROS_SVH
`define ORTHONORMAL_BASIS_FROM_AXIS_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define OBFA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define OBFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/obfa_pkg.sv
// Types, widths and codes shared by the orthonormal basis block.
`timescale 1ns / 1ps
package obfa_pkg;

  localparam int IN_FRAC_BITS  = 12;
  localparam int OUT_FRAC_BITS = 14;
  localparam int THR_FRAC_BITS = 24;
  localparam int THR_W         = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd17;

  localparam logic [1:0] OP_RIGHT    = 2'd0;
  localparam logic [1:0] OP_UP       = 2'd1;
  localparam logic [1:0] OP_FORWARD  = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int SQ_W    = 32;
  localparam int C_W     = 33;
  localparam int M_W     = 32;
  localparam int S_W     = 64;
  localparam int Q_W     = OUT_FRAC_BITS + 1;
  localparam int N_SHIFT = 2 * OUT_FRAC_BITS + 2;
  localparam int N_W     = 2 * M_W + N_SHIFT;
  localparam int P_W     = 2 * OUT_FRAC_BITS + 4 + S_W;
  localparam int A_W     = OUT_FRAC_BITS + 3 + S_W;
  localparam int SUM_W   = P_W + 1;
  localparam int NCOMP   = 6;
  localparam int OUT_W   = 16;
  localparam int MAG_MAX = 32767;

  typedef struct packed {
    logic [1:0]        operation;
    logic signed [15:0] given_x;
    logic signed [15:0] given_y;
    logic signed [15:0] given_z;
  } obfa_in_t;

  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic               used_fallback;
    logic               degenerate;
  } obfa_out_t;

  typedef struct packed {
    logic           neg;
    logic [N_W-1:0] num;
  } obfa_comp_t;

  typedef struct packed {
    logic                         valid;
    logic                         fb;
    logic [1:0]                   zero;
    logic [1:0][S_W-1:0]          s;
    obfa_comp_t [NCOMP-1:0]       comp;
  } obfa_job_t;

  typedef struct packed {
    logic [P_W-1:0]        p;
    logic signed [A_W-1:0] a;
    logic [Q_W-1:0]        q;
  } obfa_iter_t;

endpackage

>>> hdl/obfa_front.sv
// Front stages: products, fallback decision, axis vectors, lengths and numerators.
`timescale 1ns / 1ps
module obfa_front import obfa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  obfa_in_t         in_data,
  input  logic [THR_W-1:0] thr,
  output obfa_job_t        job
);

  logic                  v1_r;
  logic [1:0]            op1_r;
  logic signed [C_W-1:0] gx1_r, gy1_r, gz1_r;
  logic [SQ_W-1:0]       xx1_r, yy1_r, zz1_r;
  logic signed [SQ_W-1:0] xy1_r, xz1_r, yz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= in_data.operation;
      gx1_r <= C_W'(in_data.given_x);
      gy1_r <= C_W'(in_data.given_y);
      gz1_r <= C_W'(in_data.given_z);
      xx1_r <= SQ_W'(in_data.given_x * in_data.given_x);
      yy1_r <= SQ_W'(in_data.given_y * in_data.given_y);
      zz1_r <= SQ_W'(in_data.given_z * in_data.given_z);
      xy1_r <= SQ_W'(in_data.given_x * in_data.given_y);
      xz1_r <= SQ_W'(in_data.given_x * in_data.given_z);
      yz1_r <= SQ_W'(in_data.given_y * in_data.given_z);
    end
  end

  logic [SQ_W-1:0]      sxy, sxz, syz, g2_nxt, prim;
  logic                 fb_nxt;
  logic [C_W-1:0]       cxy, cxz, cyz, nxy, nxz, nyz, ngx, ngy, ngz;
  logic [2:0][C_W-1:0]  l_nxt, qv_nxt;
  logic [SQ_W-1:0]      sl_nxt;

  always_comb begin
    sxy    = xx1_r + yy1_r;
    sxz    = xx1_r + zz1_r;
    syz    = yy1_r + zz1_r;
    g2_nxt = xx1_r + yy1_r + zz1_r;
    prim   = (op1_r == OP_RIGHT || op1_r == OP_UP) ? sxy : sxz;
    fb_nxt = ((64'(prim) << THR_FRAC_BITS) <= (64'(thr) << (2 * IN_FRAC_BITS)));
    cxy    = C_W'(sxy);
    cxz    = C_W'(sxz);
    cyz    = C_W'(syz);
    nxy    = C_W'(0) - C_W'(xy1_r);
    nxz    = C_W'(0) - C_W'(xz1_r);
    nyz    = C_W'(0) - C_W'(yz1_r);
    ngx    = C_W'(0) - gx1_r;
    ngy    = C_W'(0) - gy1_r;
    ngz    = C_W'(0) - gz1_r;
    if (!fb_nxt) begin
      unique case (op1_r)
        OP_RIGHT: begin
          l_nxt  = {C_W'(0), gx1_r, ngy};
          sl_nxt = sxy;
          qv_nxt = {cxy, nyz, nxz};
        end
        OP_UP: begin
          l_nxt  = {C_W'(0), ngx, gy1_r};
          sl_nxt = sxy;
          qv_nxt = {cxy, nyz, nxz};
        end
        default: begin
          l_nxt  = {ngx, C_W'(0), gz1_r};
          sl_nxt = sxz;
          qv_nxt = {nyz, cxz, nxy};
        end
      endcase
    end else begin
      unique case (op1_r)
        OP_RIGHT: begin
          l_nxt  = {gx1_r, C_W'(0), ngz};
          sl_nxt = sxz;
          qv_nxt = {nyz, cxz, nxy};
        end
        OP_UP: begin
          l_nxt  = {gy1_r, ngz, C_W'(0)};
          sl_nxt = syz;
          qv_nxt = {nxz, nxy, cyz};
        end
        default: begin
          l_nxt  = {ngy, gz1_r, C_W'(0)};
          sl_nxt = syz;
          qv_nxt = {nxz, nxy, cyz};
        end
      endcase
    end
  end

  logic                v2_r, fb2_r;
  logic [2:0][C_W-1:0] l2_r, qv2_r;
  logic [SQ_W-1:0]     sl2_r, g2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fb2_r <= fb_nxt;
      l2_r  <= l_nxt;
      qv2_r <= qv_nxt;
      sl2_r <= sl_nxt;
      g2_r  <= g2_nxt;
    end
  end

  logic [S_W-1:0]              sq_len;
  logic [NCOMP-1:0][C_W-1:0]   cv;
  logic [NCOMP-1:0][M_W-1:0]   mag;
  logic [NCOMP-1:0][S_W-1:0]   csq;
  obfa_job_t                   job_nxt;
  obfa_job_t                   job_r;

  always_comb begin
    sq_len = S_W'(g2_r) * S_W'(sl2_r);
    for (int i = 0; i < 3; i++) begin
      cv[i]     = fb2_r ? qv2_r[i] : l2_r[i];
      cv[i + 3] = fb2_r ? l2_r[i] : qv2_r[i];
    end
    job_nxt.valid = v2_r;
    job_nxt.fb    = fb2_r;
    job_nxt.s[0]  = fb2_r ? sq_len : S_W'(sl2_r);
    job_nxt.s[1]  = fb2_r ? S_W'(sl2_r) : sq_len;
    job_nxt.zero[0] = (job_nxt.s[0] == '0);
    job_nxt.zero[1] = (job_nxt.s[1] == '0);
    for (int i = 0; i < NCOMP; i++) begin
      mag[i] = M_W'(cv[i][C_W-1] ? (C_W'(0) - cv[i]) : cv[i]);
      csq[i] = S_W'(mag[i]) * S_W'(mag[i]);
      job_nxt.comp[i].neg = cv[i][C_W-1];
      job_nxt.comp[i].num = N_W'(csq[i]) << N_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r.valid <= 1'b0;
    end else if (adv) begin
      job_r <= job_nxt;
    end
  end

  assign job = job_r;

endmodule

>>> hdl/obfa_norm.sv
// Normalizing pipeline: one quotient bit per stage for all six components.
`timescale 1ns / 1ps
module obfa_norm import obfa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  obfa_job_t                 job_in,
  output obfa_job_t                 job_out,
  output logic [NCOMP-1:0][Q_W-1:0] q_out
);

  obfa_job_t  job_r [Q_W];
  obfa_iter_t it_r  [Q_W][NCOMP];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int B = OUT_FRAC_BITS - k;
    obfa_job_t  jin;
    obfa_iter_t iin [NCOMP];
    obfa_iter_t inx [NCOMP];

    if (k == 0) begin : g_head
      assign jin = job_in;
      for (genvar i = 0; i < NCOMP; i++) begin : g_init
        localparam int AX = (i < 3) ? 0 : 1;
        assign iin[i].p = P_W'(job_in.s[AX]);
        assign iin[i].a = A_W'(0) - A_W'(job_in.s[AX]);
        assign iin[i].q = '0;
      end
    end else begin : g_body
      assign jin = job_r[k-1];
      for (genvar i = 0; i < NCOMP; i++) begin : g_link
        assign iin[i] = it_r[k-1][i];
      end
    end

    for (genvar i = 0; i < NCOMP; i++) begin : g_comp
      localparam int AX = (i < 3) ? 0 : 1;
      logic signed [SUM_W-1:0] pn;
      logic signed [A_W-1:0]   an;
      logic                    take;

      always_comb begin
        pn = $signed(SUM_W'(iin[i].p)) + ($signed(SUM_W'(iin[i].a)) <<< (B + 2))
             + $signed(SUM_W'(jin.s[AX]) << (2 * B + 2));
        an = iin[i].a + $signed(A_W'(jin.s[AX]) << (B + 1));
        take = (pn[P_W-1:0] <= P_W'(jin.comp[i].num));
        inx[i].p = take ? pn[P_W-1:0] : iin[i].p;
        inx[i].a = take ? an : iin[i].a;
        inx[i].q = take ? (iin[i].q | (Q_W'(1) << B)) : iin[i].q;
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          it_r[k][i] <= inx[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        job_r[k].valid <= 1'b0;
      end else if (adv) begin
        job_r[k] <= jin;
      end
    end
  end

  assign job_out = job_r[Q_W-1];
  for (genvar i = 0; i < NCOMP; i++) begin : g_out
    assign q_out[i] = it_r[Q_W-1][i].q;
  end

endmodule

>>> hdl/orthonormal_basis_from_axis.sv
// Top level of the orthonormal basis block: config register, pipeline and output register.
//
//   Port group   Role      Handshake            Beat
//   in_          input     in_valid / in_stall  operation and given vector
//   out_         result    out_valid / out_stall two unit axes and flags
//   cfg_         config    cfg_we               parallel threshold
//
// One beat is accepted every cycle unless in_stall is high; each result passes through
// three front stages, one stage per quotient bit (15) and the output register.
// The 15-stage bit-per-stage normalizer is the deepest part of the pipeline.
// Reset is synchronous on rst_n and clears all valid bits; the threshold resets to 17.
// A stall on a valid output freezes the pipeline and raises in_stall in the same cycle.
`timescale 1ns / 1ps
`include "orthonormal_basis_from_axis_macros.svh"
module orthonormal_basis_from_axis import obfa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  obfa_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output obfa_out_t        out_data,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata
);

  logic [THR_W-1:0] thr_r;
  logic             adv;
  logic             out_valid_r;
  obfa_out_t        out_data_r, out_nxt;
  obfa_job_t        front_job, norm_job;
  logic [NCOMP-1:0][Q_W-1:0]   q;
  logic [NCOMP-1:0][OUT_W-1:0] res;
  logic [NCOMP-1:0][OUT_W-1:0] mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  obfa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .thr      (thr_r),
    .job      (front_job)
  );

  obfa_norm u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .job_in  (front_job),
    .job_out (norm_job),
    .q_out   (q)
  );

  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      mag[i] = (32'(q[i]) > 32'(MAG_MAX)) ? OUT_W'(MAG_MAX) : OUT_W'(q[i]);
      if (norm_job.zero[(i < 3) ? 0 : 1]) begin
        res[i] = '0;
      end else begin
        res[i] = norm_job.comp[i].neg ? (OUT_W'(0) - mag[i]) : mag[i];
      end
    end
    out_nxt.first_x       = res[0];
    out_nxt.first_y       = res[1];
    out_nxt.first_z       = res[2];
    out_nxt.second_x      = res[3];
    out_nxt.second_y      = res[4];
    out_nxt.second_z      = res[5];
    out_nxt.used_fallback = norm_job.fb;
    out_nxt.degenerate    = |norm_job.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= norm_job.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `OBFA_ASSERT(a_stall_only_when_full, in_stall, out_valid && out_stall,
               "input stalled while output is free")
  `OBFA_ASSERT(a_first_nonzero, out_valid && !out_data.degenerate,
               out_data.first_x != 16'sd0 || out_data.first_y != 16'sd0 ||
               out_data.first_z != 16'sd0, "first axis zero without degenerate flag")
  `OBFA_ASSERT(a_second_nonzero, out_valid && !out_data.degenerate,
               out_data.second_x != 16'sd0 || out_data.second_y != 16'sd0 ||
               out_data.second_z != 16'sd0, "second axis zero without degenerate flag")
  `OBFA_ASSERT_NEXT(a_cfg_write, cfg_we, thr_r == $past(cfg_wdata),
                    "threshold write lost")

endmodule
